// ===== rtl/markup_tag_nesting_checker_assert.svh =====
// assertion macros shared by the tag nesting checker rtl
// no dependencies; assertions vanish when SYNTHESIS is defined
`ifndef MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH
`define MARKUP_TAG_NESTING_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MTNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MTNC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MTNC_ASSERT(lbl, prop, msg)
`define MTNC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/mtnc_pkg.sv =====
// shared types, codes and the void tag table of the tag nesting checker
// no dependencies
package mtnc_pkg;

  localparam int unsigned DefMaxNameLen = 16;
  localparam int unsigned DefStackDepth = 32;

  localparam int unsigned VoidCount = 15;
  localparam int unsigned VoidMaxLen = 8;

  typedef enum logic [3:0] {
    MODE_SPACE = 4'b0001,
    MODE_TAG   = 4'b0010,
    MODE_ATTR  = 4'b0100,
    MODE_WORD  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_MISMATCH = 3'd2,
    ERR_UNCLOSED = 3'd3,
    ERR_TOO_LONG = 3'd4,
    ERR_OVERFLOW = 3'd5
  } err_e;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;

  // control from the tokenizer to the void matcher
  typedef struct packed {
    logic       clr;
    logic       step;
    logic [7:0] chr;
  } void_ctl_t;

  localparam logic [7:0] VOID_WORDS [VoidCount][VoidMaxLen] = '{
    '{"!", "d", "o", "c", "t", "y", "p", "e"},
    '{"a", "r", "e", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "m", "b", "e", "d", 8'h00, 8'h00, 8'h00},
    '{"h", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "m", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
    '{"l", "i", "n", "k", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"m", "e", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "a", "r", "a", "m", 8'h00, 8'h00, 8'h00},
    '{"s", "o", "u", "r", "c", "e", 8'h00, 8'h00},
    '{"t", "r", "a", "c", "k", 8'h00, 8'h00, 8'h00},
    '{"w", "b", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] VOID_LENS [VoidCount] = '{
    4'd8, 4'd4, 4'd4, 4'd2, 4'd3, 4'd5, 4'd2, 4'd3,
    4'd5, 4'd4, 4'd4, 4'd5, 4'd6, 4'd5, 4'd3
  };

endpackage

// ===== rtl/mtnc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mtnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/mtnc_void.sv =====
// incremental matcher of the current tag name against the void tag list
// depends on mtnc_pkg
module mtnc_void #(
  parameter int unsigned LenW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtnc_pkg::void_ctl_t ctl_i,
  input  logic [LenW-1:0]    idx_i,
  output logic               is_void_o
);
  import mtnc_pkg::*;

  logic [VoidCount-1:0] alive_q, alive_d;
  logic [VoidCount-1:0] slash_q, slash_d;
  logic [VoidCount-1:0] full;
  logic                 short_idx;

  // compare at 32 bits so a narrow length field never truncates the table lengths
  assign short_idx = (32'(idx_i) < VoidMaxLen);

  always_comb begin
    alive_d = alive_q;
    slash_d = slash_q;
    for (int k = 0; k < VoidCount; k++) begin
      full[k] = alive_q[k] && (32'(idx_i) == 32'(VOID_LENS[k]));
    end
    if (ctl_i.clr) begin
      alive_d = '1;
      slash_d = '0;
    end else if (ctl_i.step) begin
      for (int k = 0; k < VoidCount; k++) begin
        alive_d[k] = alive_q[k] && short_idx && (32'(idx_i) < 32'(VOID_LENS[k])) &&
                     (VOID_WORDS[k][idx_i[2:0]] == ctl_i.chr);
        // name equals the word followed by one slash
        slash_d[k] = full[k] && (ctl_i.chr == ChSlash);
      end
    end
  end

  assign is_void_o = (|full) || (|slash_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      slash_q <= '0;
    end else begin
      alive_q <= alive_d;
      slash_q <= slash_d;
    end
  end
endmodule

// ===== rtl/markup_tag_nesting_checker.sv =====
// Tag nesting checker: takes one document byte per cycle and, after the byte
// marked as end of document, gives one verdict (valid, error code, open depth).
// A new byte can be accepted every cycle; the only stall is a verdict still
// waiting in the output register. Open tag names live in a ram of
// STACK_DEPTH rows of 2**ceil(log2(MAX_NAME_LEN)) bytes, their lengths in a
// second ram; a closing name is checked byte by byte against the stack top
// as it streams in, each ram read resolving in the next cycle.
// depends on mtnc_pkg, mtnc_ram, mtnc_void and the assertion header
`include "markup_tag_nesting_checker_assert.svh"

module markup_tag_nesting_checker #(
  parameter int unsigned MAX_NAME_LEN = mtnc_pkg::DefMaxNameLen,
  parameter int unsigned STACK_DEPTH  = mtnc_pkg::DefStackDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       end_of_document_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       document_valid_o,
  output logic [2:0] error_code_o,
  output logic [5:0] open_depth_o
);
  import mtnc_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_NAME_LEN);
  localparam int unsigned LenW  = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned TopW  = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NameDepth = STACK_DEPTH * (2 ** IdxW);

  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      err_q, err_d;
  logic            closing_q, closing_d;
  logic            overlong_q, overlong_d;
  logic            pend_q, pend_d;
  logic            mism_q, mism_d;
  logic [7:0]      pch_q, pch_d;

  logic            out_valid_q;
  logic            dv_q;
  logic [2:0]      code_q;
  logic [5:0]      depth_q;

  logic            acc, blank, mism_now, is_void;
  logic [7:0]      lc;
  logic [TopW-1:0] top;
  logic [TopW-1:0] slot;
  logic [IdxW-1:0] idx;
  logic            name_we, name_re, len_we;
  logic [7:0]      name_rdata;
  logic [LenW-1:0] len_rdata;
  logic [2:0]      code;
  logic [CntW+5:0] cnt_ext;
  void_ctl_t       vctl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign blank      = (character_i == 8'd32) ||
                      (character_i >= 8'd9 && character_i <= 8'd13);
  assign lc         = (character_i >= "A" && character_i <= "Z") ?
                      (character_i + 8'd32) : character_i;
  assign top        = TopW'(cnt_q - CntW'(1));
  assign slot       = cnt_q[TopW-1:0];
  assign idx        = len_q[IdxW-1:0];
  assign mism_now   = mism_q || (pend_q && (name_rdata != pch_q));

  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    closing_d  = closing_q;
    overlong_d = overlong_q;
    pend_d     = 1'b0;
    mism_d     = mism_q;
    pch_d      = pch_q;
    name_we    = 1'b0;
    name_re    = 1'b0;
    len_we     = 1'b0;
    vctl       = '{clr: 1'b0, step: 1'b0, chr: lc};
    code       = ERR_NONE;
    cnt_ext    = '0;
    // compare issued last cycle resolves now
    if (pend_q && (name_rdata != pch_q)) begin
      mism_d = 1'b1;
    end
    if (acc) begin
      case (mode_q)
        MODE_SPACE: begin
          if (!blank) begin
            if (character_i == ChLt) begin
              mode_d = MODE_TAG; len_d = '0; closing_d = 1'b0;
              overlong_d = 1'b0; mism_d = 1'b0; vctl.clr = 1'b1;
            end else begin
              mode_d = MODE_WORD;
            end
          end
        end
        MODE_WORD: begin
          if (blank) begin
            mode_d = MODE_SPACE;
          end else if (character_i == ChLt) begin
            mode_d = MODE_TAG; len_d = '0; closing_d = 1'b0;
            overlong_d = 1'b0; mism_d = 1'b0; vctl.clr = 1'b1;
          end
        end
        MODE_TAG, MODE_ATTR: begin
          if (character_i == ChGt) begin
            mode_d = MODE_SPACE;
            if (err_q == ERR_NONE && !overlong_q) begin
              if (closing_q) begin
                if (cnt_q == '0) begin
                  err_d = ERR_EMPTY;
                end else if (len_rdata != len_q || mism_now) begin
                  err_d = ERR_MISMATCH;
                end else begin
                  cnt_d = cnt_q - CntW'(1);
                end
              end else if (!is_void) begin
                if (cnt_q >= CntW'(STACK_DEPTH)) begin
                  err_d = ERR_OVERFLOW;
                end else begin
                  len_we = 1'b1;
                  cnt_d  = cnt_q + CntW'(1);
                end
              end
            end
          end else if (mode_q == MODE_TAG) begin
            if (blank) begin
              mode_d = MODE_ATTR;
            end else if (len_q == '0 && !closing_q && !overlong_q &&
                         character_i == ChSlash) begin
              closing_d = 1'b1;
            end else if (len_q < LenW'(MAX_NAME_LEN)) begin
              len_d     = len_q + LenW'(1);
              vctl.step = 1'b1;
              if (closing_q) begin
                name_re = 1'b1;
                pend_d  = 1'b1;
                pch_d   = lc;
              end else begin
                name_we = (cnt_q < CntW'(STACK_DEPTH));
              end
            end else begin
              overlong_d = 1'b1;
              if (err_q == ERR_NONE) begin
                err_d = ERR_TOO_LONG;
              end
            end
          end
        end
        default: mode_d = MODE_SPACE;
      endcase
      if (end_of_document_i) begin
        code = (err_d == ERR_NONE && cnt_d != '0) ? ERR_UNCLOSED : err_d;
        // depth as it stands after this byte, before the return to idle
        cnt_ext = {6'd0, cnt_d};
        mode_d = MODE_SPACE; len_d = '0; cnt_d = '0; err_d = ERR_NONE;
        closing_d = 1'b0; overlong_d = 1'b0; pend_d = 1'b0; mism_d = 1'b0;
        vctl.clr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SPACE;
      len_q       <= '0;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      closing_q   <= 1'b0;
      overlong_q  <= 1'b0;
      pend_q      <= 1'b0;
      mism_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      closing_q   <= closing_d;
      overlong_q  <= overlong_d;
      pend_q      <= pend_d;
      mism_q      <= mism_d;
      if (acc && end_of_document_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pch_q <= pch_d;
    if (acc && end_of_document_i) begin
      dv_q    <= (code == ERR_NONE);
      code_q  <= code;
      depth_q <= cnt_ext[5:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign document_valid_o = dv_q;
  assign error_code_o     = code_q;
  assign open_depth_o     = depth_q;

  mtnc_ram #(.Width(8), .Depth(NameDepth)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i ({slot, idx}),
    .wdata_i (lc),
    .re_i    (name_re),
    .raddr_i ({top, idx}),
    .rdata_o (name_rdata)
  );

  mtnc_ram #(.Width(LenW), .Depth(STACK_DEPTH)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (slot),
    .wdata_i (len_q),
    .re_i    (1'b1),
    .raddr_i (top),
    .rdata_o (len_rdata)
  );

  mtnc_void #(.LenW(LenW)) u_void (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (vctl),
    .idx_i     (len_q),
    .is_void_o (is_void)
  );

  `MTNC_ASSERT(a_cnt_bound, cnt_q <= CntW'(STACK_DEPTH), "open count beyond stack depth")
  `MTNC_ASSERT(a_cnt_idle, !acc |=> $stable(cnt_q), "open count moved without an item")
  `MTNC_ASSERT(a_err_sticky, (err_q != ERR_NONE && !(acc && end_of_document_i)) |=> err_q != ERR_NONE, "latched error lost")
  `MTNC_ASSERT(a_pend_closing, pend_q |-> closing_q, "name compare outside a closing tag")
endmodule
